// File: design/tms_pkg.sv
package tms_pkg;

  // Fixed field widths
  localparam int FUNC_W     = 3;
  localparam int STATUS_W   = 3;
  localparam int STEP_W     = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int unsigned BLANK_CODE     = 2;
  localparam int unsigned ORIGIN_RESET   = 2048;
  localparam int unsigned LIMIT_RESET    = 1000000;
  localparam int unsigned START_RESET    = 0;
  localparam int unsigned ACCEPT_RESET   = 1;
  localparam int unsigned REJECT_RESET   = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD    = 3'd0,
    FN_WRITE   = 3'd1,
    FN_READ    = 3'd2,
    FN_RESTART = 3'd3,
    FN_STEP    = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_RUNNING  = 3'd0,
    STAT_ACCEPT   = 3'd1,
    STAT_REJECT   = 3'd2,
    STAT_NO_RULE  = 3'd3,
    STAT_LIMIT    = 3'd4,
    STAT_OFF_TAPE = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START  = 3'd0,
    CFG_ACCEPT = 3'd1,
    CFG_REJECT = 3'd2,
    CFG_ORIGIN = 3'd3,
    CFG_LIMIT  = 3'd4
  } cfg_idx_e;

  // Write strobes from the sequencer to the two memories
  typedef struct packed {
    logic tape_we;
    logic rule_we;
  } mem_wr_t;

endpackage

// File: design/tms_ram.sv
module tms_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 3,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read, old data on a same-cycle write
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/tms_ctrl.sv
module tms_ctrl
  import tms_pkg::*;
#(
  parameter int NUM_STATES   = 64,
  parameter int TAPE_DEPTH   = 4096,
  parameter int SYMBOL_CODES = 8,
  localparam int STATE_W    = $clog2(NUM_STATES),
  localparam int ADDR_W     = $clog2(TAPE_DEPTH),
  localparam int SYM_W      = $clog2(SYMBOL_CODES),
  localparam int RULE_DEPTH = NUM_STATES * SYMBOL_CODES,
  localparam int RULE_AW    = $clog2(RULE_DEPTH),
  localparam int RULE_W     = 2 + STATE_W + SYM_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [STATE_W-1:0]  rule_state_i,
  input  logic [SYM_W-1:0]    rule_read_i,
  input  logic [STATE_W-1:0]  rule_next_i,
  input  logic [SYM_W-1:0]    rule_write_i,
  input  logic                rule_left_i,
  input  logic                rule_valid_i,
  input  logic [ADDR_W-1:0]   cell_addr_i,
  input  logic [SYM_W-1:0]    cell_code_i,
  input  logic [STATE_W-1:0]  start_state_i,
  input  logic [STATE_W-1:0]  accept_state_i,
  input  logic [STATE_W-1:0]  reject_state_i,
  input  logic [ADDR_W-1:0]   head_origin_i,
  input  logic [STEP_W-1:0]   step_limit_i,
  output mem_wr_t             mem_wr_o,
  output logic [ADDR_W-1:0]   tape_waddr_o,
  output logic [SYM_W-1:0]    tape_wdata_o,
  output logic [ADDR_W-1:0]   tape_raddr_o,
  input  logic [SYM_W-1:0]    tape_rdata_i,
  output logic [RULE_AW-1:0]  rule_waddr_o,
  output logic [RULE_W-1:0]   rule_wdata_o,
  output logic [RULE_AW-1:0]  rule_raddr_o,
  input  logic [RULE_W-1:0]   rule_rdata_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [STATE_W-1:0]  machine_state_o,
  output logic [ADDR_W-1:0]   head_pos_o,
  output logic [SYM_W-1:0]    symbol_out_o,
  output logic [STEP_W-1:0]   steps_done_o
);

  localparam int CLR_DEPTH = (TAPE_DEPTH > RULE_DEPTH) ? TAPE_DEPTH : RULE_DEPTH;
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  localparam logic [ADDR_W-1:0] ORIGIN_RST = ADDR_W'(ORIGIN_RESET % TAPE_DEPTH);

  typedef enum logic [2:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_TAPE,
    FSM_RULE,
    FSM_DONE
  } fsm_e;

  fsm_e                fsm_q, fsm_d;
  logic [CLR_W-1:0]    clr_q, clr_d;
  logic [STATE_W-1:0]  mstate_q, mstate_d;
  logic [ADDR_W-1:0]   head_q, head_d;
  logic [STEP_W-1:0]   count_q, count_d;
  logic                off_q, off_d;
  logic                lk_valid_q, lk_valid_d;
  logic [STATE_W-1:0]  lk_next_q, lk_next_d;
  logic [SYM_W-1:0]    lk_write_q, lk_write_d;
  logic                lk_left_q, lk_left_d;
  logic                rd_ok_q, rd_ok_d;
  logic                sym_ok_q, sym_ok_d;
  logic [SYM_W-1:0]    sym_q, sym_d;
  status_e             status_q, status_d;
  logic                done_q, done_d;
  logic [ADDR_W-1:0]   origin_mod;

  function automatic logic [RULE_AW-1:0] rule_index(input logic [STATE_W-1:0] st,
                                                    input logic [SYM_W-1:0] sym);
    return RULE_AW'(32'(st) * SYMBOL_CODES + 32'(sym));
  endfunction

  function automatic logic key_ok(input logic [STATE_W-1:0] st,
                                  input logic [SYM_W-1:0] sym);
    return (32'(st) < NUM_STATES) && (32'(sym) < SYMBOL_CODES);
  endfunction

  function automatic status_e calc_status(input logic lk_ok);
    status_e s;
    priority if (off_q) begin
      s = STAT_OFF_TAPE;
    end else if (mstate_q == accept_state_i) begin
      s = STAT_ACCEPT;
    end else if (mstate_q == reject_state_i) begin
      s = STAT_REJECT;
    end else if (count_q >= step_limit_i) begin
      s = STAT_LIMIT;
    end else if (!lk_ok) begin
      s = STAT_NO_RULE;
    end else begin
      s = STAT_RUNNING;
    end
    return s;
  endfunction

  // origin register never exceeds twice the depth
  assign origin_mod = (32'(head_origin_i) >= TAPE_DEPTH) ?
                      head_origin_i - ADDR_W'(TAPE_DEPTH) : head_origin_i;

  always_comb begin
    fsm_d      = fsm_q;
    clr_d      = clr_q;
    mstate_d   = mstate_q;
    head_d     = head_q;
    count_d    = count_q;
    off_d      = off_q;
    lk_valid_d = lk_valid_q;
    lk_next_d  = lk_next_q;
    lk_write_d = lk_write_q;
    lk_left_d  = lk_left_q;
    rd_ok_d    = rd_ok_q;
    sym_ok_d   = sym_ok_q;
    sym_d      = sym_q;
    status_d   = status_q;
    done_d     = 1'b0;

    mem_wr_o     = '0;
    tape_waddr_o = head_q;
    tape_wdata_o = lk_write_q;
    tape_raddr_o = head_q;
    rule_waddr_o = rule_index(rule_state_i, rule_read_i);
    rule_wdata_o = {rule_valid_i, rule_next_i, rule_write_i, rule_left_i};
    rule_raddr_o = rule_index(mstate_q, tape_rdata_i);

    unique case (fsm_q)
      FSM_CLEAR: begin
        mem_wr_o.tape_we = 32'(clr_q) < TAPE_DEPTH;
        tape_waddr_o     = clr_q[ADDR_W-1:0];
        tape_wdata_o     = SYM_W'(BLANK_CODE);
        mem_wr_o.rule_we = 32'(clr_q) < RULE_DEPTH;
        rule_waddr_o     = clr_q[RULE_AW-1:0];
        rule_wdata_o     = '0;
        clr_d            = clr_q + 1'b1;
        if (clr_q == CLR_W'(CLR_DEPTH - 1)) begin
          fsm_d = FSM_IDLE;
        end
      end
      FSM_IDLE: begin
        if (start_i) begin
          fsm_d   = FSM_TAPE;
          sym_d   = '0;
          rd_ok_d = 1'b0;
          unique case (func_e'(func_i))
            FN_LOAD: begin
              mem_wr_o.rule_we = key_ok(rule_state_i, rule_read_i);
            end
            FN_WRITE: begin
              mem_wr_o.tape_we = 32'(cell_addr_i) < TAPE_DEPTH;
              tape_waddr_o     = cell_addr_i;
              tape_wdata_o     = cell_code_i;
            end
            FN_READ: begin
              tape_raddr_o = cell_addr_i;
              rd_ok_d      = 32'(cell_addr_i) < TAPE_DEPTH;
            end
            FN_RESTART: begin
              mstate_d = start_state_i;
              head_d   = origin_mod;
              count_d  = '0;
              off_d    = 1'b0;
            end
            FN_STEP: begin
              if (calc_status(lk_valid_q) == STAT_RUNNING) begin
                mem_wr_o.tape_we = 1'b1;
                sym_d            = lk_write_q;
                mstate_d         = lk_next_q;
                if (lk_left_q) begin
                  if (head_q == '0) off_d = 1'b1;
                  else head_d = head_q - 1'b1;
                end else begin
                  if (32'(head_q) == TAPE_DEPTH - 1) off_d = 1'b1;
                  else head_d = head_q + 1'b1;
                end
                if (count_q != '1) begin
                  count_d = count_q + 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      FSM_TAPE: begin
        // cell read data lands now; head cell read goes out
        if (rd_ok_q) begin
          sym_d = tape_rdata_i;
        end
        fsm_d = FSM_RULE;
      end
      FSM_RULE: begin
        sym_ok_d = key_ok(mstate_q, tape_rdata_i);
        fsm_d    = FSM_DONE;
      end
      FSM_DONE: begin
        lk_valid_d = sym_ok_q & rule_rdata_i[RULE_W-1];
        lk_next_d  = rule_rdata_i[RULE_W-2 -: STATE_W];
        lk_write_d = rule_rdata_i[SYM_W:1];
        lk_left_d  = rule_rdata_i[0];
        status_d   = calc_status(lk_valid_d);
        done_d     = 1'b1;
        fsm_d      = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q      <= FSM_CLEAR;
      clr_q      <= '0;
      mstate_q   <= '0;
      head_q     <= ORIGIN_RST;
      count_q    <= '0;
      off_q      <= 1'b0;
      lk_valid_q <= 1'b0;
      lk_next_q  <= '0;
      lk_write_q <= '0;
      lk_left_q  <= 1'b0;
      rd_ok_q    <= 1'b0;
      sym_ok_q   <= 1'b0;
      sym_q      <= '0;
      status_q   <= STAT_RUNNING;
      done_q     <= 1'b0;
    end else begin
      fsm_q      <= fsm_d;
      clr_q      <= clr_d;
      mstate_q   <= mstate_d;
      head_q     <= head_d;
      count_q    <= count_d;
      off_q      <= off_d;
      lk_valid_q <= lk_valid_d;
      lk_next_q  <= lk_next_d;
      lk_write_q <= lk_write_d;
      lk_left_q  <= lk_left_d;
      rd_ok_q    <= rd_ok_d;
      sym_ok_q   <= sym_ok_d;
      sym_q      <= sym_d;
      status_q   <= status_d;
      done_q     <= done_d;
    end
  end

  // machine registers only change on the accept edge, after the strobe cycle
  assign busy_o          = (fsm_q != FSM_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign machine_state_o = mstate_q;
  assign head_pos_o      = head_q;
  assign symbol_out_o    = sym_q;
  assign steps_done_o    = count_q;

endmodule

// File: design/turing_machine_step_engine_top.sv
// Single-tape Turing machine engine. Drive an item on the payload ports with
// start high; it is taken on a clock edge where busy is low. Each item (rule
// load, tape cell write, tape cell read, restart, step) produces exactly one
// result, shown for one cycle with done_o high; the receiver cannot stall, so
// it must take every result in that cycle. An item runs in order: the accept
// cycle performs the action, then the head cell is read from the tape memory,
// then the rule for (state, head symbol) is read from the rule memory, then
// the status is formed and registered. That tape-then-rule read chain through
// two memories with registered reads sets the length of an item; the result
// strobe overlaps the next accept, but no new item is taken while one is in
// flight. After reset both memories are swept (blank tape, empty rule table)
// over max(TAPE_DEPTH, NUM_STATES*SYMBOL_CODES) addresses, 4096 at the defaults,
// with busy high; configuration writes are taken at all times and should be
// made only while no item is in flight.
module turing_machine_step_engine_top
  import tms_pkg::*;
#(
  parameter int NUM_STATES   = 64,
  parameter int TAPE_DEPTH   = 4096,
  parameter int SYMBOL_CODES = 8,
  localparam int STATE_W    = $clog2(NUM_STATES),
  localparam int ADDR_W     = $clog2(TAPE_DEPTH),
  localparam int SYM_W      = $clog2(SYMBOL_CODES)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // item channel
  input  logic                  start,
  output logic                  busy,
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [STATE_W-1:0]    rule_state_i,
  input  logic [SYM_W-1:0]      rule_read_i,
  input  logic [STATE_W-1:0]    rule_next_i,
  input  logic [SYM_W-1:0]      rule_write_i,
  input  logic                  rule_left_i,
  input  logic                  rule_valid_i,
  input  logic [ADDR_W-1:0]     cell_addr_i,
  input  logic [SYM_W-1:0]      cell_code_i,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // result strobe and payload
  output logic                  done_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic [STATE_W-1:0]    machine_state_o,
  output logic [ADDR_W-1:0]     head_pos_o,
  output logic [SYM_W-1:0]      symbol_out_o,
  output logic [STEP_W-1:0]     steps_done_o
);

  localparam int RULE_DEPTH = NUM_STATES * SYMBOL_CODES;
  localparam int RULE_AW    = $clog2(RULE_DEPTH);
  localparam int RULE_W     = 2 + STATE_W + SYM_W;

  // ---------------------------------------------------------------------
  // Configuration registers. Writes to unlisted indexes are dropped.
  // ---------------------------------------------------------------------
  logic [STATE_W-1:0] start_state_q;
  logic [STATE_W-1:0] accept_state_q;
  logic [STATE_W-1:0] reject_state_q;
  logic [ADDR_W-1:0]  head_origin_q;
  logic [STEP_W-1:0]  step_limit_q;
  logic               cfg_xfer;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_state_q  <= STATE_W'(START_RESET);
      accept_state_q <= STATE_W'(ACCEPT_RESET);
      reject_state_q <= STATE_W'(REJECT_RESET);
      head_origin_q  <= ADDR_W'(ORIGIN_RESET % TAPE_DEPTH);
      step_limit_q   <= STEP_W'(LIMIT_RESET);
    end else if (cfg_xfer) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_START:  start_state_q  <= cfg_data_i[STATE_W-1:0];
        CFG_ACCEPT: accept_state_q <= cfg_data_i[STATE_W-1:0];
        CFG_REJECT: reject_state_q <= cfg_data_i[STATE_W-1:0];
        CFG_ORIGIN: head_origin_q  <= cfg_data_i[ADDR_W-1:0];
        CFG_LIMIT:  step_limit_q   <= cfg_data_i[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer and the two memories it reads, modifies and writes back.
  // Every item ends with a fresh lookup of the rule under the head, so the
  // cached rule is always current when the next step uses it; writes land
  // before the following reads, so no forwarding is needed.
  // ---------------------------------------------------------------------
  mem_wr_t            mem_wr;
  logic [ADDR_W-1:0]  tape_waddr;
  logic [SYM_W-1:0]   tape_wdata;
  logic [ADDR_W-1:0]  tape_raddr;
  logic [SYM_W-1:0]   tape_rdata;
  logic [RULE_AW-1:0] rule_waddr;
  logic [RULE_W-1:0]  rule_wdata;
  logic [RULE_AW-1:0] rule_raddr;
  logic [RULE_W-1:0]  rule_rdata;

  tms_ctrl #(
    .NUM_STATES   (NUM_STATES),
    .TAPE_DEPTH   (TAPE_DEPTH),
    .SYMBOL_CODES (SYMBOL_CODES)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_o          (busy),
    .func_i          (func_i),
    .rule_state_i    (rule_state_i),
    .rule_read_i     (rule_read_i),
    .rule_next_i     (rule_next_i),
    .rule_write_i    (rule_write_i),
    .rule_left_i     (rule_left_i),
    .rule_valid_i    (rule_valid_i),
    .cell_addr_i     (cell_addr_i),
    .cell_code_i     (cell_code_i),
    .start_state_i   (start_state_q),
    .accept_state_i  (accept_state_q),
    .reject_state_i  (reject_state_q),
    .head_origin_i   (head_origin_q),
    .step_limit_i    (step_limit_q),
    .mem_wr_o        (mem_wr),
    .tape_waddr_o    (tape_waddr),
    .tape_wdata_o    (tape_wdata),
    .tape_raddr_o    (tape_raddr),
    .tape_rdata_i    (tape_rdata),
    .rule_waddr_o    (rule_waddr),
    .rule_wdata_o    (rule_wdata),
    .rule_raddr_o    (rule_raddr),
    .rule_rdata_i    (rule_rdata),
    .done_o          (done_o),
    .status_o        (status_o),
    .machine_state_o (machine_state_o),
    .head_pos_o      (head_pos_o),
    .symbol_out_o    (symbol_out_o),
    .steps_done_o    (steps_done_o)
  );

  // tape: one symbol code per cell
  tms_ram #(
    .DEPTH (TAPE_DEPTH),
    .WIDTH (SYM_W)
  ) u_tape (
    .clk_i   (clk_i),
    .we_i    (mem_wr.tape_we),
    .waddr_i (tape_waddr),
    .wdata_i (tape_wdata),
    .raddr_i (tape_raddr),
    .rdata_o (tape_rdata)
  );

  // rule table: {valid, next state, write symbol, move left}
  tms_ram #(
    .DEPTH (RULE_DEPTH),
    .WIDTH (RULE_W)
  ) u_rules (
    .clk_i   (clk_i),
    .we_i    (mem_wr.rule_we),
    .waddr_i (rule_waddr),
    .wdata_i (rule_wdata),
    .raddr_i (rule_raddr),
    .rdata_o (rule_rdata)
  );

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // fixed sequence: every accepted item is followed by its result strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##4 done_o)
    else $error("result strobe missing after accepted item");

  // one result per item, never on consecutive cycles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // head always stays on the tape
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (32'(head_pos_o) < TAPE_DEPTH))
    else $error("head position beyond tape");

endmodule
